>>> hw/rtl/ftd_pkg.sv
package ftd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int TAB_N     = 256;
	localparam int TAB_BITS  = $clog2(TAB_N);
	localparam int NAX       = 3;
	localparam int AX_W      = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;
	localparam int LG_W      = 24;
	localparam int MA_W      = 32;
	localparam int MB_W      = 18;
	localparam int PROD_W    = MA_W + MB_W;

	localparam logic [15:0] GAIN_POS_RST  = 16'd1280;
	localparam logic [15:0] GAIN_RATE_RST = 16'd1536;
	localparam logic [15:0] STEP_RST      = 16'd655;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// exponents 0.4, 1.4 (rate path) then 0.7, 1.2 (angle path), Q2.16
	localparam logic [3:0][MB_W-1:0] POW_EXPS = {
		18'd78643, 18'd45875, 18'd91750, 18'd26214
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_POS_X  = 3'd0,
		CFG_GAIN_POS_Y  = 3'd1,
		CFG_GAIN_POS_Z  = 3'd2,
		CFG_GAIN_RATE_X = 3'd3,
		CFG_GAIN_RATE_Y = 3'd4,
		CFG_GAIN_RATE_Z = 3'd5,
		CFG_TIME_STEP   = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_NORM,
		S_LOG,
		S_PMUL,
		S_PEXP,
		S_GMUL_R,
		S_GSAT_R,
		S_TMUL_R,
		S_UPD_R,
		S_GMUL_A,
		S_GSAT_A,
		S_TMUL_A,
		S_UPD_A,
		S_DONE
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF)
			r = S32_MAX;
		else if (v < -64'sh0000_0000_8000_0000)
			r = S32_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] bitv;
		v = v_in;
		r = 64'd0;
		bitv = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (v >= r + bitv) begin
				v = v - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	function automatic logic [TAB_N-1:0][15:0] build_log();
		logic [TAB_N-1:0][15:0] t;
		logic [63:0] x;
		logic [15:0] r;
		for (int i = 0; i < TAB_N; i++) begin
			x = (64'd1 << 30) + ((64'(i) << 30) / TAB_N);
			r = 16'd0;
			for (int b = 1; b <= 16; b++) begin
				x = (x * x) >> 30;
				if (x >= (64'd2 << 30)) begin
					x = x >> 1;
					r = r | (16'd1 << (16 - b));
				end
			end
			t[i] = r;
		end
		return t;
	endfunction

	function automatic logic [TAB_N-1:0][31:0] build_exp();
		logic [TAB_N-1:0][31:0] t;
		logic [16:0][63:0] root;
		logic [63:0] f16;
		logic [63:0] y;
		root[0] = 64'd2 << 30;
		for (int b = 1; b <= 16; b++)
			root[b] = isqrt64(root[b-1] << 30);
		for (int i = 0; i < TAB_N; i++) begin
			f16 = (64'(i) << 16) / TAB_N;
			y = 64'd1 << 30;
			for (int b = 1; b <= 16; b++) begin
				if (f16[16-b])
					y = (y * root[b]) >> 30;
			end
			t[i] = y[31:0];
		end
		return t;
	endfunction

	localparam logic [TAB_N-1:0][15:0] LOG_TAB = build_log();
	localparam logic [TAB_N-1:0][31:0] EXP_TAB = build_exp();

endpackage

>>> hw/rtl/ftd_mul.sv
module ftd_mul (
	input  logic                                clk,
	input  logic signed [ftd_pkg::MA_W-1:0]     op_a,
	input  logic signed [ftd_pkg::MB_W-1:0]     op_b,
	output logic signed [ftd_pkg::PROD_W-1:0]   prod
);
	import ftd_pkg::*;

	// shared signed multiplier, product registered
	always_ff @(posedge clk) begin
		prod <= PROD_W'(op_a) * PROD_W'(op_b);
	end

endmodule

>>> hw/rtl/finite_time_tracking_differentiator.sv
// Finite-time tracking differentiator for three attitude angles.
// Input channel (in_valid/in_ready): one request per sampling tick carrying
// meas_x/y/z, signed Q16.16. Output channel (out_valid/out_ready): one request
// per tick with the new angle and rate estimates and the error per axis.
// Configuration: write cfg_data to register cfg_index when cfg_wr_en is high
// (0..2 angle gains, 3..5 rate gains, 6 time step); write only while idle.
// One shared signed 32x18 multiplier serves every product; a small sequencer
// steps each axis through error, leading-one search, table log, four power
// evaluations and four gain/step products; zero error skips the normalize,
// log and power part. in_ready is high only in idle, so a new tick is not
// accepted until the sequencer has finished the previous one. The result
// sits in an output register; the sequencer returns to idle once it is
// loaded, so a stalled receiver only blocks the next tick at its end.
// Reset clears both estimates, restores the gains (5.0, 6.0) and step
// (655/65536), and leaves the output channel empty.
module finite_time_tracking_differentiator #(
	parameter int AXES = ftd_pkg::NAX
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ftd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ftd_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [31:0]             meas_x,
	input  logic signed [31:0]             meas_y,
	input  logic signed [31:0]             meas_z,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [31:0]             est_angle_x,
	output logic signed [31:0]             est_angle_y,
	output logic signed [31:0]             est_angle_z,
	output logic signed [31:0]             est_rate_x,
	output logic signed [31:0]             est_rate_y,
	output logic signed [31:0]             est_rate_z,
	output logic signed [31:0]             err_x,
	output logic signed [31:0]             err_y,
	output logic signed [31:0]             err_z
);
	import ftd_pkg::*;

	state_t state_q, state_d;

	// configuration
	logic [15:0] gain_pos_q  [NAX];
	logic [15:0] gain_rate_q [NAX];
	logic [15:0] step_q;

	// filter state and captured request
	logic signed [31:0] angle_q [NAX];
	logic signed [31:0] rate_q  [NAX];
	logic signed [31:0] err_q   [NAX];
	logic signed [31:0] meas_q  [NAX];

	// working registers
	logic [AX_W-1:0]        ax_q;
	logic signed [31:0]     e_q;
	logic [31:0]            m_q;
	logic [4:0]             k_q;
	logic signed [LG_W-1:0] lg_q;
	logic [1:0]             pi_q;
	logic signed [32:0]     acc_q;
	logic signed [31:0]     sum2_q;
	logic signed [31:0]     sum1_q;
	logic signed [31:0]     val_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] o_angle_q [NAX];
	logic signed [31:0] o_rate_q  [NAX];
	logic signed [31:0] o_err_q   [NAX];

	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod;

	logic in_acc;
	logic last_ax;
	logic out_free;

	// combinational datapath terms
	logic signed [32:0]     diff_c;
	logic signed [31:0]     e_c;
	logic signed [LG_W-1:0] lg_c;
	logic signed [19:0]     sh_c;
	logic [19:0]            nsh_c;
	logic [TAB_BITS-1:0]    eidx_c;
	logic [31:0]            y_c;
	logic [63:0]            shl_c;
	logic [31:0]            pw_c;
	logic signed [32:0]     term_c;
	logic signed [31:0]     psum_c;
	logic signed [31:0]     sh8_c;
	logic signed [31:0]     sh16_c;

	ftd_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	assign in_acc   = in_valid && in_ready;
	assign last_ax  = (ax_q == AX_W'(AXES - 1));
	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_ERR;
			S_ERR:    state_d = (e_c == 32'sd0) ? S_GMUL_R : S_NORM;
			S_NORM:   if (m_q[31]) state_d = S_LOG;
			S_LOG:    state_d = S_PMUL;
			S_PMUL:   state_d = S_PEXP;
			S_PEXP:   state_d = (pi_q == 2'd3) ? S_GMUL_R : S_PMUL;
			S_GMUL_R: state_d = S_GSAT_R;
			S_GSAT_R: state_d = S_TMUL_R;
			S_TMUL_R: state_d = S_UPD_R;
			S_UPD_R:  state_d = S_GMUL_A;
			S_GMUL_A: state_d = S_GSAT_A;
			S_GSAT_A: state_d = S_TMUL_A;
			S_TMUL_A: state_d = S_UPD_A;
			S_UPD_A:  state_d = last_ax ? S_DONE : S_ERR;
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: handshake and multiplier operand select
	always_comb begin
		in_ready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			S_IDLE:   in_ready = 1'b1;
			S_PMUL: begin
				mul_a = MA_W'(lg_q);
				mul_b = POW_EXPS[pi_q];
			end
			S_GMUL_R: begin
				mul_a = sum2_q;
				mul_b = {2'b00, gain_rate_q[ax_q]};
			end
			S_TMUL_R, S_TMUL_A: begin
				mul_a = val_q;
				mul_b = {2'b00, step_q};
			end
			S_GMUL_A: begin
				mul_a = sum1_q;
				mul_b = {2'b00, gain_pos_q[ax_q]};
			end
			default: ;
		endcase
	end

	// error, log and power terms, and the scaled products
	always_comb begin
		diff_c = 33'(meas_q[ax_q]) - 33'(angle_q[ax_q]);
		e_c    = sat32(64'(diff_c));
		lg_c   = ((LG_W'(k_q) - LG_W'(FRAC_BITS)) <<< 16)
			+ LG_W'(LOG_TAB[m_q[30 -: TAB_BITS]]);

		// integer part of the exponent is signed: small errors give a negative one
		sh_c   = 20'($signed(prod[PROD_W-1:32])) + 20'(FRAC_BITS) - 20'd30;
		nsh_c  = -sh_c;
		eidx_c = prod[31 -: TAB_BITS];
		y_c    = EXP_TAB[eidx_c];
		shl_c  = {32'd0, y_c} << sh_c[5:0];
		if (!sh_c[19]) begin
			if (sh_c > 20'sd32)
				pw_c = 32'h7FFF_FFFF;
			else if (shl_c > 64'h7FFF_FFFF)
				pw_c = 32'h7FFF_FFFF;
			else
				pw_c = shl_c[31:0];
		end else begin
			if (nsh_c >= 20'd63)
				pw_c = 32'd0;
			else
				pw_c = 32'({32'd0, y_c} >> nsh_c[5:0]);
		end
		term_c = e_q[31] ? -$signed({1'b0, pw_c}) : $signed({1'b0, pw_c});
		psum_c = sat32(64'(acc_q) + 64'(term_c));

		sh8_c  = sat32(64'(prod) >>> 8);
		sh16_c = sat32(64'(prod) >>> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NAX; i++) begin
				gain_pos_q[i]  <= GAIN_POS_RST;
				gain_rate_q[i] <= GAIN_RATE_RST;
			end
			step_q <= STEP_RST;
		end else if (cfg_wr_en) begin
			priority case (cfg_reg_t'(cfg_index))
				CFG_GAIN_POS_X:  gain_pos_q[0]  <= cfg_data;
				CFG_GAIN_POS_Y:  gain_pos_q[1]  <= cfg_data;
				CFG_GAIN_POS_Z:  gain_pos_q[2]  <= cfg_data;
				CFG_GAIN_RATE_X: gain_rate_q[0] <= cfg_data;
				CFG_GAIN_RATE_Y: gain_rate_q[1] <= cfg_data;
				CFG_GAIN_RATE_Z: gain_rate_q[2] <= cfg_data;
				CFG_TIME_STEP:   step_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// filter state and sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NAX; i++) begin
				angle_q[i] <= '0;
				rate_q[i]  <= '0;
				err_q[i]   <= '0;
			end
			ax_q <= '0;
			pi_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					ax_q <= '0;
				end
				S_ERR: begin
					err_q[ax_q] <= e_c;
					pi_q        <= '0;
				end
				S_PEXP: begin
					pi_q <= pi_q + 2'd1;
				end
				S_UPD_R: begin
					rate_q[ax_q] <= sat32(64'(rate_q[ax_q]) + 64'(sh16_c));
				end
				S_UPD_A: begin
					angle_q[ax_q] <= sat32(64'(angle_q[ax_q]) + 64'(sh16_c));
					if (!last_ax)
						ax_q <= ax_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	// working payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			meas_q[0] <= meas_x;
			meas_q[1] <= meas_y;
			meas_q[2] <= meas_z;
		end
		unique case (state_q)
			S_ERR: begin
				e_q    <= e_c;
				m_q    <= e_c[31] ? 32'(-e_c) : e_c;
				k_q    <= 5'd31;
				sum1_q <= '0;
				sum2_q <= '0;
			end
			S_NORM: begin
				// hunt the leading one: byte steps, then single bits
				if (!m_q[31]) begin
					if (m_q[31:24] == 8'd0) begin
						m_q <= m_q << 8;
						k_q <= k_q - 5'd8;
					end else begin
						m_q <= m_q << 1;
						k_q <= k_q - 5'd1;
					end
				end
			end
			S_LOG: lg_q <= lg_c;
			S_PEXP: begin
				if (!pi_q[0])
					acc_q <= term_c;
				else if (!pi_q[1])
					sum2_q <= psum_c;
				else
					sum1_q <= psum_c;
			end
			S_GSAT_R: val_q <= sh8_c;
			S_UPD_R:  val_q <= sat32(64'(rate_q[ax_q]) + 64'(sh16_c));
			S_GSAT_A: val_q <= sat32(64'(rate_q[ax_q]) + 64'(sh8_c));
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			for (int i = 0; i < NAX; i++) begin
				o_angle_q[i] <= angle_q[i];
				o_rate_q[i]  <= rate_q[i];
				o_err_q[i]   <= err_q[i];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign est_angle_x = o_angle_q[0];
	assign est_angle_y = o_angle_q[1];
	assign est_angle_z = o_angle_q[2];
	assign est_rate_x  = o_rate_q[0];
	assign est_rate_y  = o_rate_q[1];
	assign est_rate_z  = o_rate_q[2];
	assign err_x       = o_err_q[0];
	assign err_y       = o_err_q[1];
	assign err_z       = o_err_q[2];

	// an accepted request always starts the first axis
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_ERR && ax_q == '0))
		else $error("accepted request did not start axis 0");

	// axis counter never leaves the configured range
	a_ax_range: assert property (@(posedge clk) disable iff (!arst_n)
		ax_q <= AX_W'(AXES - 1))
		else $error("axis counter out of range");

	// leading-one search only runs on a nonzero magnitude
	a_norm_nz: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NORM |-> m_q != 32'd0)
		else $error("normalize on zero magnitude");

	// a new result is only raised when finishing a request
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside completion");

endmodule

>>> tb/finite_time_tracking_differentiator_tb.sv
`timescale 1ns / 1ps

// Scoreboard: holds the differentiator state and register copies, predicts each tick.
class ftd_scoreboard;
	typedef struct {
		logic signed [31:0] angle [3];
		logic signed [31:0] rate [3];
		logic signed [31:0] err [3];
	} tick_result_t;

	logic [15:0] log_lut [256];
	logic [63:0] exp_lut [256];
	logic [15:0] g_pos [3];
	logic [15:0] g_rate [3];
	logic [15:0] dt;
	logic signed [31:0] ang_st [3];
	logic signed [31:0] rate_st [3];
	tick_result_t pending [$];
	int n_fail;
	int n_checked;

	function new();
		logic [63:0] sq [17];
		logic [63:0] x, y, f16, v, r, bitv;
		logic [15:0] lg;
		sq[0] = 64'd2 << 30;
		for (int b = 1; b <= 16; b++) begin
			v = sq[b-1] << 30;
			r = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv >>= 2;
			while (bitv != 0) begin
				if (v >= r + bitv) begin
					v = v - (r + bitv);
					r = (r >> 1) + bitv;
				end else begin
					r = r >> 1;
				end
				bitv >>= 2;
			end
			sq[b] = r;
		end
		for (int i = 0; i < 256; i++) begin
			x = (64'd1 << 30) + ((64'(i) << 30) / 256);
			f16 = (64'(i) << 16) / 256;
			y = 64'd1 << 30;
			lg = 0;
			for (int b = 1; b <= 16; b++) begin
				x = (x * x) >> 30;
				if (x >= (64'd2 << 30)) begin
					x >>= 1;
					lg |= 16'd1 << (16 - b);
				end
				if (f16[16-b]) y = (y * sq[b]) >> 30;
			end
			log_lut[i] = lg;
			exp_lut[i] = y;
		end
		n_fail = 0;
		n_checked = 0;
		clear_state();
	endfunction

	function void clear_state();
		for (int a = 0; a < 3; a++) begin
			g_pos[a] = 16'd1280;
			g_rate[a] = 16'd1536;
			ang_st[a] = 0;
			rate_st[a] = 0;
		end
		dt = 16'd655;
	endfunction

	function void write_reg(ftd_pkg::cfg_reg_t idx, logic [15:0] val);
		case (idx)
			ftd_pkg::CFG_GAIN_POS_X: g_pos[0] = val;
			ftd_pkg::CFG_GAIN_POS_Y: g_pos[1] = val;
			ftd_pkg::CFG_GAIN_POS_Z: g_pos[2] = val;
			ftd_pkg::CFG_GAIN_RATE_X: g_rate[0] = val;
			ftd_pkg::CFG_GAIN_RATE_Y: g_rate[1] = val;
			ftd_pkg::CFG_GAIN_RATE_Z: g_rate[2] = val;
			ftd_pkg::CFG_TIME_STEP: dt = val;
			default: ;
		endcase
	endfunction

	function logic signed [31:0] clip(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// |e|^p through log2 and exp2 lookups; p in Q2.16
	function longint mag_pow(logic [31:0] m, longint p);
		int k, sh;
		logic [63:0] frac31, idx, y;
		longint lg, ex, n, fr;
		k = 31;
		while (k > 0 && !m[k]) k--;
		frac31 = (64'(m) << (31 - k)) - (64'd1 << 31);
		idx = (frac31 * 256) >> 31;
		lg = (longint'(k) - 16) * 65536 + longint'(log_lut[idx]);
		ex = (lg * p) >>> 16;
		n = ex >>> 16;
		fr = ex - n * 65536;
		y = exp_lut[(fr * 256) >> 16];
		sh = int'(n) + 16 - 30;
		if (sh >= 0) begin
			if (sh > 32) return 64'sd2147483647;
			y = y << sh;
			return (y > 64'd2147483647) ? 64'sd2147483647 : longint'(y);
		end
		if (-sh >= 63) return 0;
		return longint'(y >> (-sh));
	endfunction

	function longint signed_pow(logic signed [31:0] e, longint p);
		logic [31:0] m;
		if (e == 0) return 0;
		m = (e < 0) ? -e : e;
		return (e < 0) ? -mag_pow(m, p) : mag_pow(m, p);
	endfunction

	function logic signed [31:0] correction(logic signed [31:0] e, longint pa, longint pb,
			logic [15:0] g);
		logic signed [31:0] s;
		s = clip(signed_pow(e, pa) + signed_pow(e, pb));
		return clip((longint'(s) * longint'(g)) >>> 8);
	endfunction

	function logic signed [31:0] scale_dt(logic signed [31:0] v);
		return clip((longint'(v) * longint'(dt)) >>> 16);
	endfunction

	function void note_tick(logic signed [31:0] meas [3]);
		tick_result_t t;
		logic signed [31:0] e, rd, ad;
		for (int a = 0; a < 3; a++) begin
			e = clip(longint'(meas[a]) - longint'(ang_st[a]));
			rd = correction(e, 26214, 91750, g_rate[a]);
			rate_st[a] = clip(longint'(rate_st[a]) + longint'(scale_dt(rd)));
			ad = clip(longint'(rate_st[a]) + longint'(correction(e, 45875, 78643, g_pos[a])));
			ang_st[a] = clip(longint'(ang_st[a]) + longint'(scale_dt(ad)));
			t.angle[a] = ang_st[a];
			t.rate[a] = rate_st[a];
			t.err[a] = e;
		end
		pending.push_back(t);
	endfunction

	function void check_field(string name, logic signed [31:0] exp_v, logic signed [31:0] act);
		if (act !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act);
			n_fail++;
		end
	endfunction

	function void check_tick(logic signed [31:0] ang [3], logic signed [31:0] rt [3],
			logic signed [31:0] er [3]);
		tick_result_t t;
		string ax;
		if (pending.size() == 0) begin
			$error("result with no tick outstanding");
			n_fail++;
			return;
		end
		t = pending.pop_front();
		n_checked++;
		for (int a = 0; a < 3; a++) begin
			ax = (a == 0) ? "x" : (a == 1) ? "y" : "z";
			check_field({"est_angle_", ax}, t.angle[a], ang[a]);
			check_field({"est_rate_", ax}, t.rate[a], rt[a]);
			check_field({"err_", ax}, t.err[a], er[a]);
		end
	endfunction
endclass

module finite_time_tracking_differentiator_tb;
	import ftd_pkg::*;

	localparam int LIMIT_CYCLES = 1_000_000;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [31:0] meas_x, meas_y, meas_z;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] est_angle_x, est_angle_y, est_angle_z;
	logic signed [31:0] est_rate_x, est_rate_y, est_rate_z;
	logic signed [31:0] err_x, err_y, err_z;

	ftd_scoreboard tick_board;
	int cycle_count;
	int burst_left;
	int n_cfg_writes;

	finite_time_tracking_differentiator u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.meas_x(meas_x), .meas_y(meas_y), .meas_z(meas_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.est_angle_x(est_angle_x), .est_angle_y(est_angle_y), .est_angle_z(est_angle_z),
		.est_rate_x(est_rate_x), .est_rate_y(est_rate_y), .est_rate_z(est_rate_z),
		.err_x(err_x), .err_y(err_y), .err_z(err_z)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Timeout guard: count every cycle, give up at the limit.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= LIMIT_CYCLES) begin
				$display("finite_time_tracking_differentiator_tb NOT OK");
				$finish;
			end
		end
	end

	// Receiver: stall on a pattern that cycles through runs of ready and not ready,
	// with quiet stretches of constant ready and random stretches mixed in.
	initial begin
		int phase;
		logic signed [31:0] ang [3], rt [3], er [3];
		phase = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				ang = '{est_angle_x, est_angle_y, est_angle_z};
				rt = '{est_rate_x, est_rate_y, est_rate_z};
				er = '{err_x, err_y, err_z};
				tick_board.check_tick(ang, rt, er);
			end
			phase = (phase + 1) % 600;
			if (phase < 200)
				out_ready <= 1'b1;
			else if (phase < 400)
				out_ready <= (phase % 7) < 3;
			else
				out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Write one register while the block is idle; mirror it in the scoreboard.
	task automatic write_cfg(cfg_reg_t idx, logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		tick_board.write_reg(idx, val);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		n_cfg_writes++;
	endtask

	// Offer one request; hold valid and payload until accepted.
	task automatic send_tick(logic signed [31:0] mx, logic signed [31:0] my,
			logic signed [31:0] mz);
		logic signed [31:0] m [3];
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		// let the drop of the previous valid take effect first
		@(posedge clk);
		in_valid <= 1'b1;
		meas_x <= mx;
		meas_y <= my;
		meas_z <= mz;
		do @(posedge clk); while (!in_ready);
		m = '{mx, my, mz};
		tick_board.note_tick(m);
		in_valid <= 1'b0;
	endtask

	// Drain: wait for every outstanding result, then let the sequencer settle.
	task automatic drain();
		while (tick_board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_meas(logic signed [31:0] center);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return center + $signed($urandom_range(0, 2000)) - 1000;
			2: return center + $signed($urandom_range(0, 400000)) - 200000;
			3: return $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
			4: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return center;
		endcase
	endfunction

	task automatic random_phase(int count);
		logic signed [31:0] c [3];
		for (int i = 0; i < count; i++) begin
			for (int a = 0; a < 3; a++)
				c[a] = rand_meas(tick_board.ang_st[a]);
			send_tick(c[0], c[1], c[2]);
		end
	endtask

	task automatic random_config();
		logic [15:0] v;
		for (int r = 0; r <= int'(CFG_TIME_STEP); r++) begin
			case ($urandom_range(0, 3))
				0: v = 16'h0000;
				1: v = 16'hFFFF;
				default: v = $urandom_range(0, 16'hFFFF);
			endcase
			write_cfg(cfg_reg_t'(r), v);
		end
	endtask

	initial begin
		tick_board = new();
		n_cfg_writes = 0;
		burst_left = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_GAIN_POS_X;
		cfg_data = '0;
		in_valid = 1'b0;
		meas_x = '0;
		meas_y = '0;
		meas_z = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero error, field extremes, sign and bit toggles at reset gains.
		send_tick(0, 0, 0);
		send_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000);
		send_tick(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh0001_0000);
		send_tick(32'sh0000_0001, -32'sh0000_0001, 32'sh5555_5555);
		send_tick(32'shAAAA_AAAA, 32'sh0000_8000, 32'shFFFF_FFFF);
		send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		drain();

		// Zero step: estimates must hold still.
		write_cfg(CFG_TIME_STEP, 16'h0000);
		send_tick(32'sh0003_0000, -32'sh0002_0000, 32'sh1234_5678);
		send_tick(0, 0, 0);
		drain();

		// Largest gains and step: push the sums into saturation.
		for (int r = 0; r <= int'(CFG_TIME_STEP); r++)
			write_cfg(cfg_reg_t'(r), 16'hFFFF);
		send_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0001);
		send_tick(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sh0000_0001);
		send_tick(0, 0, 0);
		drain();

		// Zero gains: only the rate term moves the angle.
		for (int r = 0; r <= int'(CFG_TIME_STEP); r++)
			write_cfg(cfg_reg_t'(r), 16'h0000);
		write_cfg(CFG_TIME_STEP, 16'd1);
		send_tick(32'sh0010_0000, -32'sh0010_0000, 32'sh0000_0100);
		drain();

		// Back to typical settings for the first random stretch.
		write_cfg(CFG_GAIN_POS_X, 16'd1280);
		write_cfg(CFG_GAIN_POS_Y, 16'd1280);
		write_cfg(CFG_GAIN_POS_Z, 16'd1280);
		write_cfg(CFG_GAIN_RATE_X, 16'd1536);
		write_cfg(CFG_GAIN_RATE_Y, 16'd1536);
		write_cfg(CFG_GAIN_RATE_Z, 16'd1536);
		write_cfg(CFG_TIME_STEP, 16'd655);
		random_phase(400);
		drain();

		// Further phases at random settings, each drained before the next write.
		for (int ph = 0; ph < 5; ph++) begin
			random_config();
			random_phase(200);
			drain();
		end

		$display("covered %0d ticks over several gain/step settings, %0d register writes",
			tick_board.n_checked, n_cfg_writes);
		if (tick_board.n_fail == 0 && tick_board.pending.size() == 0)
			$display("finite_time_tracking_differentiator_tb OK");
		else
			$display("finite_time_tracking_differentiator_tb NOT OK");
		$finish;
	end
endmodule
